// ===== hdl/assert_macros.svh =====
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition a implies condition b in the same cycle, outside reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");

// condition a implies condition b in the next cycle, outside reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

// condition b holds in the cycle after reset
`define ASSERT_AFTER_RESET(label, clk, rst, b) \
   label: assert property (@(posedge clk) (rst) |=> (b)) \
      else $error("post-reset check failed");

`endif

// ===== hdl/pdu_pkg.sv =====
package pdu_pkg;

   // sample format codes
   localparam logic [1:0] FMT_S32_LE  = 2'd0;
   localparam logic [1:0] FMT_S24_LE  = 2'd1;
   localparam logic [1:0] FMT_S24_3LE = 2'd2;
   localparam logic [1:0] FMT_S16_LE  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] REG_SAMPLE_FORMAT   = 2'd0;
   localparam logic [1:0] REG_STREAM_CHANNELS = 2'd1;
   localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd2;

   // reset values of the configuration registers
   localparam logic [1:0] RST_SAMPLE_FORMAT   = FMT_S16_LE;
   localparam logic [3:0] RST_STREAM_CHANNELS = 4'd2;
   localparam logic [1:0] RST_ACTIVE_CHANNELS = 2'd2;

   localparam int MAX_STREAM_CHANNELS = 8;

   typedef struct packed {
      logic [1:0] sample_format;
      logic [3:0] stream_channels;
      logic [1:0] active_channels;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        channel;
      logic [31:0] sample;
      logic        frame_end;
   } result_type;

   // index of the last byte in the container of a format
   function automatic logic [1:0] container_last(input logic [1:0] fmt);
      logic [1:0] last;
      case (fmt)
         FMT_S32_LE:  last = 2'd3;
         FMT_S24_LE:  last = 2'd3;
         FMT_S24_3LE: last = 2'd2;
         FMT_S16_LE:  last = 2'd1;
         default:     last = 2'd1;
      endcase
      return last;
   endfunction

endpackage

// ===== hdl/pdu_unpack.sv =====
module pdu_unpack #(
   parameter int MAX_STREAM_CHANNELS = pdu_pkg::MAX_STREAM_CHANNELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                end_of_buffer,
   input  pdu_pkg::cfg_type    cfg,
   output pdu_pkg::result_type result
);

   localparam int PosW = (MAX_STREAM_CHANNELS > 1) ? $clog2(MAX_STREAM_CHANNELS) : 1;
   localparam int CntW = ($clog2(MAX_STREAM_CHANNELS + 1) > 4) ?
                         $clog2(MAX_STREAM_CHANNELS + 1) : 4;
   localparam logic [CntW-1:0] MaxChans = CntW'(MAX_STREAM_CHANNELS);

   logic [1:0]      byte_pos_ff, byte_pos_in;
   logic [PosW-1:0] chan_pos_ff, chan_pos_in;
   logic [23:0]     partial_ff, partial_in;

   logic [CntW-1:0] stream_ext, chans, frame_chans, act_ext, pos_ext, pos_inc;
   logic [1:0]      act;
   logic [23:0]     partial_eff;
   logic [31:0]     raw;
   logic [31:0]     q31;
   logic            done;
   logic            emit;

   // channel counts, saturated
   always_comb begin
      stream_ext  = CntW'(cfg.stream_channels);
      chans       = (stream_ext > MaxChans) ? MaxChans : stream_ext;
      frame_chans = (chans == '0) ? CntW'(1) : chans;
      act         = (cfg.active_channels > 2'd2) ? 2'd2 : cfg.active_channels;
      act_ext     = CntW'(act);
      pos_ext     = CntW'(chan_pos_ff);
      pos_inc     = pos_ext + CntW'(1);
   end

   // byte merge into the container
   always_comb begin
      partial_eff = (byte_pos_ff == 2'd0) ? 24'd0 : partial_ff;
      case (byte_pos_ff)
         2'd0:    raw = {24'd0, data_byte};
         2'd1:    raw = {16'd0, data_byte, partial_eff[7:0]};
         2'd2:    raw = {8'd0, data_byte, partial_eff[15:0]};
         2'd3:    raw = {data_byte, partial_eff[23:0]};
         default: raw = {24'd0, data_byte};
      endcase
      done = (byte_pos_ff >= pdu_pkg::container_last(cfg.sample_format));
   end

   // left-justify to q1.31
   always_comb begin
      case (cfg.sample_format)
         pdu_pkg::FMT_S32_LE: q31 = raw;
         pdu_pkg::FMT_S16_LE: q31 = {raw[15:0], 16'd0};
         default:             q31 = {raw[23:0], 8'd0};
      endcase
   end

   // result of this byte
   always_comb begin
      emit             = (act_ext <= chans) && (pos_ext < act_ext);
      result.valid     = done && emit;
      result.channel   = chan_pos_ff[0];
      result.sample    = q31;
      result.frame_end = (pos_inc == act_ext);
   end

   // position update
   always_comb begin
      if (done) begin
         byte_pos_in = 2'd0;
         partial_in  = 24'd0;
         chan_pos_in = (pos_inc >= frame_chans) ? '0 : PosW'(pos_inc);
      end else begin
         byte_pos_in = byte_pos_ff + 2'd1;
         partial_in  = raw[23:0];
         chan_pos_in = chan_pos_ff;
      end
      if (end_of_buffer) begin
         byte_pos_in = 2'd0;
         chan_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= 2'd0;
         chan_pos_ff <= '0;
      end else if (step) begin
         byte_pos_ff <= byte_pos_in;
         chan_pos_ff <= chan_pos_in;
      end
   end

   // partial bytes are ignored at byte position zero
   always_ff @(posedge clock) begin
      if (step) begin
         partial_ff <= partial_in;
      end
   end

endmodule

// ===== hdl/pcm_deinterleave_unpacker_core.sv =====
// pcm deinterleave unpacker
// req channel: one byte of an interleaved little-endian pcm stream per request,
//    req_tlast marks the last byte of a buffer and restarts the frame position.
// rsp channel: one sample per completed container of an active channel, signed
//    q1.31 in rsp_tdata, channel index in rsp_tuser, rsp_tlast on the last
//    active channel of the frame.
// csr channel: register writes (0 sample format, 1 stream channels, 2 active
//    channels), always ready, meant for idle periods.
// path: a request enters an input register, and its result, once its container
//    is complete, is taken into the output register, which drives rsp_tvalid.
// throughput: one byte per cycle while the output is not stalled; the only loop is
//    the position and partial sample update.
// stall: when rsp_tready is low the output register holds its sample and the
//    input register holds one more byte; req_tready falls only once both are
//    full with a byte that would produce a result.
// reset: clears the positions and both valid flags and loads the register
//    defaults (s16_le, two stream channels, two active channels).
`include "assert_macros.svh"

module pcm_deinterleave_unpacker_core #(
   parameter int MAX_STREAM_CHANNELS = pdu_pkg::MAX_STREAM_CHANNELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sample
   output logic        rsp_tuser,   // [0] channel
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   pdu_pkg::cfg_type    cfg_ff;
   pdu_pkg::result_type result;

   logic        in_vld_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_vld_ff;
   logic [31:0] out_sample_ff;
   logic        out_chan_ff;
   logic        out_end_ff;
   logic        out_free;
   logic        move;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format   <= pdu_pkg::RST_SAMPLE_FORMAT;
         cfg_ff.stream_channels <= pdu_pkg::RST_STREAM_CHANNELS;
         cfg_ff.active_channels <= pdu_pkg::RST_ACTIVE_CHANNELS;
      end else if (csr_valid) begin
         case (csr_index)
            pdu_pkg::REG_SAMPLE_FORMAT:   cfg_ff.sample_format   <= csr_data[1:0];
            pdu_pkg::REG_STREAM_CHANNELS: cfg_ff.stream_channels <= csr_data;
            pdu_pkg::REG_ACTIVE_CHANNELS: cfg_ff.active_channels <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // stage handshake
   assign out_free   = !out_vld_ff || rsp_tready;
   assign move       = in_vld_ff && (!result.valid || out_free);
   assign req_tready = !in_vld_ff || move;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // byte placement and sample assembly
   pdu_unpack #(
      .MAX_STREAM_CHANNELS (MAX_STREAM_CHANNELS)
   ) u_unpack (
      .clock         (clock),
      .reset         (reset),
      .step          (move),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_last_ff),
      .cfg           (cfg_ff),
      .result        (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move && result.valid) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move && result.valid) begin
         out_sample_ff <= result.sample;
         out_chan_ff   <= result.channel;
         out_end_ff    <= result.frame_end;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_sample_ff;
   assign rsp_tuser  = out_chan_ff;
   assign rsp_tlast  = out_end_ff;

   // checks
   `ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !in_vld_ff && !out_vld_ff)
   `ASSERT_IMPLY(a_ready_only_when_full, clock, reset, !req_tready,
                 in_vld_ff && result.valid && out_vld_ff && !rsp_tready)
   `ASSERT_NEXT(a_input_stage_holds, clock, reset, in_vld_ff && !move,
                in_vld_ff && $stable(in_byte_ff) && $stable(in_last_ff))
   `ASSERT_NEXT(a_result_kept, clock, reset, out_vld_ff && !rsp_tready,
                out_vld_ff && $stable(out_sample_ff))

endmodule
